// File: rtl/veta_pkg.sv
// Package: constants, types and register codes for the voxel energy/time accumulator.
`timescale 1ns / 1ps
package veta_pkg;
  localparam int MaxChannels = 4096;
  localparam int MaxSegments = 16;
  localparam int ChW = $clog2(MaxChannels);
  localparam int SegW = $clog2(MaxSegments + 1);
  localparam int IdxW = $clog2(MaxSegments);

  localparam logic [2:0] REG_SEG_X = 3'd0;
  localparam logic [2:0] REG_SEG_Y = 3'd1;
  localparam logic [2:0] REG_SEG_Z = 3'd2;
  localparam logic [2:0] REG_LEN_X = 3'd3;
  localparam logic [2:0] REG_LEN_Y = 3'd4;
  localparam logic [2:0] REG_LEN_Z = 3'd5;
  localparam logic [2:0] REG_FRONT_Z = 3'd6;

  localparam logic OP_DEPOSIT = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  typedef struct packed {
    logic        operation;
    logic [19:0] pos_x;
    logic [19:0] pos_y;
    logic [19:0] pos_z;
    logic [31:0] deposit_energy;
    logic [39:0] deposit_time;
  } in_item_t;

  typedef struct packed {
    logic            accepted;
    logic [11:0]     channel;
    logic            new_entry;
    logic [31:0]     energy_total;
    logic [39:0]     mean_time;
    logic [19:0]     center_x;
    logic [19:0]     center_y;
    logic [19:0]     center_z;
  } out_item_t;

  // divider unit control
  typedef struct packed {
    logic         start;
    logic [127:0] num;
    logic [39:0]  den;
  } div_req_t;
endpackage

// File: rtl/veta_if.sv
// Valid/ready stream interfaces for input and result transactions.
`timescale 1ns / 1ps
interface veta_in_if;
  logic valid;
  logic ready;
  veta_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface veta_out_if;
  logic valid;
  logic ready;
  veta_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/veta_ram.sv
// Generic single-port synchronous RAM with registered read.
`timescale 1ns / 1ps
module veta_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// File: rtl/veta_div.sv
// Restoring divider: 128-bit dividend by 40-bit divisor, one quotient bit per cycle.
`timescale 1ns / 1ps
module veta_div (
  input  logic                clk,
  input  logic                rst,
  input  veta_pkg::div_req_t  req,
  output logic                done,
  output logic [127:0]        quot,
  output logic [40:0]         rem
);
  import veta_pkg::*;
  logic [127:0] q;
  logic [40:0]  r;
  logic [39:0]  d;
  logic [7:0]   cnt;
  logic         busy;
  logic [41:0]  shifted;
  logic [41:0]  diff;

  assign shifted = {r, q[127]};
  assign diff = shifted - {2'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        q <= req.num;
        r <= '0;
        d <= req.den;
        cnt <= 8'd128;
      end else if (busy) begin
        if (!diff[41]) begin
          r <= diff[40:0];
          q <= {q[126:0], 1'b1};
        end else begin
          r <= shifted[40:0];
          q <= {q[126:0], 1'b0};
        end
        cnt <= cnt - 8'd1;
        if (cnt == 8'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
  assign quot = q;
  assign rem = r;
endmodule

// File: rtl/voxel_energy_time_accumulator.sv
// Top level: voxel quantization, per-channel energy/time accumulation, centre decode.
//  channel | dir | payload
//  in      | in  | operation, pos_x/y/z, deposit_energy, deposit_time
//  out     | out | accepted, channel, new_entry, energy_total, mean_time, center_x/y/z
//  apb     | in  | seven registers at byte addresses 4*i
// A deposit has its result after ten divisions (three cell indices, the weighted time,
// three index decodes, three centres), which share one bit-serial divider. An ignored
// deposit (zero energy) goes from acceptance straight to S_OUT without any division.
// After reset a clearing pass sweeps all 4096 entries of the valid memory; no transaction is
// accepted meanwhile. Clear sweeps the same 4096 entries before its result is written.
// The output register frees the input side; a finished item waits in S_OUT while it is full.
`timescale 1ns / 1ps
module voxel_energy_time_accumulator (
  input  logic               clk,
  input  logic               rst,
  veta_in_if.sink            in_ch,
  veta_out_if.source         out_ch,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import veta_pkg::*;

  typedef enum logic [4:0] {
    S_SWEEP, S_IDLE, S_CX, S_CY, S_CZ, S_CHAN, S_RD, S_RDW, S_TIME, S_WR,
    S_DV1, S_DV2, S_DV3, S_CEN_X, S_CEN_Y, S_CEN_Z, S_OUT
  } state_t;

  state_t state;
  logic [4:0]  seg_x, seg_y, seg_z;
  logic [17:0] len_x, len_y, len_z;
  logic [19:0] front_z;

  in_item_t    it;
  out_item_t   res;
  out_item_t   wrk;
  logic        res_valid;
  logic        div_wait;
  logic        clr_pend;

  logic [4:0]  nx, ny, nz;
  logic [17:0] lx, ly, lz;
  logic [IdxW-1:0] ci, cj, ck;
  logic [ChW-1:0] vox, ch, addr_sweep;
  logic [ChW-1:0] vox_lin;
  logic [ChW:0] sweep_cnt;
  logic [9:0]  nxy;
  logic [ChW-1:0] dvox;
  // DV2 divides the quotient of DV1 again (vox / nx) % ny; DV3 uses the stored voxel / nx*ny
  logic [ChW-1:0] vox_st;

  // memories
  logic vm_we, vm_wd, vm_rd;
  logic dm_we;
  logic [ChW-1:0] m_addr;
  logic [83:0] dm_wd, dm_rd;
  logic [31:0] e_old;
  logic [39:0] t_old;
  logic fresh;

  div_req_t dreq;
  logic dv_done;
  logic [127:0] dv_q;
  logic [40:0] dv_r;

  assign nx = (seg_x == 5'd0) ? 5'd1 : (seg_x > 5'(MaxSegments)) ? 5'(MaxSegments) : seg_x;
  assign ny = (seg_y == 5'd0) ? 5'd1 : (seg_y > 5'(MaxSegments)) ? 5'(MaxSegments) : seg_y;
  assign nz = (seg_z == 5'd0) ? 5'd1 : (seg_z > 5'(MaxSegments)) ? 5'(MaxSegments) : seg_z;
  assign lx = (len_x == '0) ? 18'd1 : len_x;
  assign ly = (len_y == '0) ? 18'd1 : len_y;
  assign lz = (len_z == '0) ? 18'd1 : len_z;
  assign nxy = 10'(nx) * 10'(ny);
  assign vox_lin = ChW'(nxy) * ChW'(ck) + ChW'(nx) * ChW'(cj) + ChW'(ci);

  veta_ram #(.Width(1), .Depth(MaxChannels)) u_valid (
    .clk(clk), .we(vm_we), .addr(m_addr), .wdata(vm_wd), .rdata(vm_rd));
  veta_ram #(.Width(84), .Depth(MaxChannels)) u_data (
    .clk(clk), .we(dm_we), .addr(m_addr), .wdata(dm_wd), .rdata(dm_rd));

  veta_div u_div (.clk(clk), .rst(rst), .req(dreq), .done(dv_done), .quot(dv_q), .rem(dv_r));

  // APB
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      seg_x <= 5'd2; seg_y <= 5'd2; seg_z <= 5'd1;
      len_x <= 18'd2000; len_y <= 18'd2000; len_z <= 18'd2000;
      front_z <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr[4:2])
        REG_SEG_X: seg_x <= pwdata[4:0];
        REG_SEG_Y: seg_y <= pwdata[4:0];
        REG_SEG_Z: seg_z <= pwdata[4:0];
        REG_LEN_X: len_x <= pwdata[17:0];
        REG_LEN_Y: len_y <= pwdata[17:0];
        REG_LEN_Z: len_z <= pwdata[17:0];
        REG_FRONT_Z: front_z <= pwdata[19:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    case (paddr[4:2])
      REG_SEG_X: prdata = {27'd0, seg_x};
      REG_SEG_Y: prdata = {27'd0, seg_y};
      REG_SEG_Z: prdata = {27'd0, seg_z};
      REG_LEN_X: prdata = {14'd0, len_x};
      REG_LEN_Y: prdata = {14'd0, len_y};
      REG_LEN_Z: prdata = {14'd0, len_z};
      REG_FRONT_Z: prdata = {{12{front_z[19]}}, front_z};
      default: prdata = '0;
    endcase
  end

  assign in_ch.ready = (state == S_IDLE);
  assign out_ch.valid = res_valid;
  assign out_ch.data = res;

  // cell offsets (numerator for index division), signed 23 bits
  logic signed [22:0] offx, offy, offz;
  assign offx = 23'(signed'(it.pos_x)) * 23'sd2 + 23'(signed'({1'b0, lx}));
  assign offy = 23'(signed'(it.pos_y)) * 23'sd2 + 23'(signed'({1'b0, ly}));
  assign offz = 23'(signed'(it.pos_z)) - 23'(signed'(front_z));

  // centre numerators, signed 33 bits
  logic [ChW:0] two_i1;
  logic signed [32:0] cnum;
  logic [32:0] cmag;
  logic [4:0] cn;
  logic signed [19:0] fz_s;
  assign fz_s = signed'(front_z);

  function automatic logic [IdxW-1:0] clampi(input logic [127:0] q, input logic [4:0] n);
    clampi = (q > 128'(n - 5'd1)) ? IdxW'(n - 5'd1) : IdxW'(q);
  endfunction

  function automatic logic [19:0] sat20(input logic signed [31:0] v);
    if (v < -32'sd524288) sat20 = 20'h80000;
    else if (v > 32'sd524287) sat20 = 20'h7FFFF;
    else sat20 = v[19:0];
  endfunction

  logic neg_c;
  logic signed [31:0] cq;
  logic [IdxW-1:0] di, dj;
  logic [ChW-1:0] dk;
  logic [127:0] esum_w;
  logic [31:0] esum;
  logic [79:0] p_new, p_old;

  always_comb begin
    case (state)
      S_CEN_X: begin two_i1 = {ChW'(di), 1'b1}; cn = nx;
        cnum = 33'(signed'({1'b0, lx})) * 33'(signed'({1'b0, two_i1}))
             - 33'(signed'({1'b0, lx})) * 33'(signed'({1'b0, nx})); end
      S_CEN_Y: begin two_i1 = {ChW'(dj), 1'b1}; cn = ny;
        cnum = 33'(signed'({1'b0, ly})) * 33'(signed'({1'b0, two_i1}))
             - 33'(signed'({1'b0, ly})) * 33'(signed'({1'b0, ny})); end
      default: begin two_i1 = {dk, 1'b1}; cn = nz;
        cnum = 33'(signed'({1'b0, lz})) * 33'(signed'({1'b0, two_i1})); end
    endcase
    cmag = cnum[32] ? 33'(-cnum) : 33'(cnum);
  end

  assign cq = neg_c ? -32'(signed'({1'b0, dv_q[30:0]})) : 32'(signed'({1'b0, dv_q[30:0]}));

  always_comb begin
    esum_w = 128'(e_old) + 128'(it.deposit_energy);
    esum = esum_w[32] ? 32'hFFFFFFFF : esum_w[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_SWEEP;
      sweep_cnt <= '0;
      res_valid <= 1'b0;
      div_wait <= 1'b0;
      clr_pend <= 1'b0;
      dreq.start <= 1'b0;
    end else begin
      dreq.start <= 1'b0;
      if (out_ch.valid && out_ch.ready) res_valid <= 1'b0;
      case (state)
        S_SWEEP: begin
          sweep_cnt <= sweep_cnt + 1'b1;
          if (sweep_cnt == (ChW+1)'(MaxChannels - 1)) begin
            state <= clr_pend ? S_OUT : S_IDLE;
            clr_pend <= 1'b0;
            sweep_cnt <= '0;
          end
        end
        S_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            it <= in_ch.data;
            wrk <= '0;
            if (in_ch.data.operation == OP_CLEAR) begin
              clr_pend <= 1'b1;
              state <= S_SWEEP;
            end else if (in_ch.data.deposit_energy == '0) begin
              state <= S_OUT;
            end else begin
              state <= S_CX;
              div_wait <= 1'b0;
            end
          end
        end
        S_CX, S_CY, S_CZ: begin
          if (!div_wait) begin
            div_wait <= 1'b1;
            dreq.start <= 1'b1;
            case (state)
              S_CX: begin dreq.num <= 128'(offx) * 128'(nx); dreq.den <= 40'(lx) << 1; end
              S_CY: begin dreq.num <= 128'(offy) * 128'(ny); dreq.den <= 40'(ly) << 1; end
              default: begin dreq.num <= 128'(offz) * 128'(nz); dreq.den <= 40'(lz); end
            endcase
          end else if (dv_done) begin
            div_wait <= 1'b0;
            case (state)
              S_CX: begin ci <= offx[22] ? '0 : clampi(dv_q, nx); state <= S_CY; end
              S_CY: begin cj <= offy[22] ? '0 : clampi(dv_q, ny); state <= S_CZ; end
              default: begin ck <= offz[22] ? '0 : clampi(dv_q, nz); state <= S_CHAN; end
            endcase
          end
        end
        S_CHAN: begin
          vox <= vox_lin;
          if (nx == 5'd2 && ny == 5'd2) begin
            ch <= {(ChW-2)'(0), it.pos_y[19], it.pos_x[19] ^ it.pos_y[19]};
          end else begin
            ch <= vox_lin;
          end
          state <= S_RD;
        end
        S_RD: state <= S_RDW;
        S_RDW: begin
          fresh <= !vm_rd;
          e_old <= vm_rd ? dm_rd[83:52] : '0;
          t_old <= vm_rd ? dm_rd[51:12] : '0;
          dvox <= vm_rd ? dm_rd[11:0] : vox;
          p_new <= 80'(it.deposit_time) * 80'(it.deposit_energy);
          p_old <= (vm_rd ? 80'(dm_rd[51:12]) * 80'(dm_rd[83:52]) : '0);
          state <= S_TIME;
        end
        S_TIME: begin
          if (!div_wait) begin
            div_wait <= 1'b1;
            dreq.start <= 1'b1;
            dreq.num <= 128'(p_new) + 128'(p_old);
            dreq.den <= 40'(e_old) + 40'(it.deposit_energy);
          end else if (dv_done) begin
            div_wait <= 1'b0;
            wrk.mean_time <= dv_q[39:0];
            wrk.energy_total <= esum;
            state <= S_WR;
          end
        end
        S_WR: state <= S_DV1;
        S_DV1, S_DV2, S_DV3: begin
          if (!div_wait) begin
            div_wait <= 1'b1;
            dreq.start <= 1'b1;
            dreq.num <= (state == S_DV3) ? 128'(vox_st) : 128'(dvox);
            dreq.den <= (state == S_DV1) ? 40'(nx) : (state == S_DV2) ? 40'(ny) : 40'(nxy);
          end else if (dv_done) begin
            div_wait <= 1'b0;
            case (state)
              S_DV1: begin di <= IdxW'(dv_r); dvox <= ChW'(dv_q); state <= S_DV2; end
              S_DV2: begin dj <= IdxW'(dv_r); state <= S_DV3; end
              default: begin dk <= ChW'(dv_q); state <= S_CEN_X; end
            endcase
          end
        end
        S_CEN_X, S_CEN_Y, S_CEN_Z: begin
          if (!div_wait) begin
            div_wait <= 1'b1;
            dreq.start <= 1'b1;
            neg_c <= cnum[32];
            dreq.num <= 128'(cmag) + 128'(cn);
            dreq.den <= 40'(cn) << 1;
          end else if (dv_done) begin
            div_wait <= 1'b0;
            case (state)
              S_CEN_X: begin wrk.center_x <= sat20(cq); state <= S_CEN_Y; end
              S_CEN_Y: begin wrk.center_y <= sat20(cq); state <= S_CEN_Z; end
              default: begin
                wrk.center_z <= sat20(cq + 32'(fz_s));
                wrk.accepted <= 1'b1;
                wrk.channel <= 12'(ch);
                wrk.new_entry <= fresh;
                state <= S_OUT;
              end
            endcase
          end
        end
        S_OUT: begin
          if (!res_valid) begin
            res <= wrk;
            res_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_RDW) vox_st <= vm_rd ? dm_rd[11:0] : vox;
  end

  always_comb begin
    vm_we = 1'b0; vm_wd = 1'b0; dm_we = 1'b0;
    m_addr = ch; dm_wd = {esum, wrk.mean_time, 12'(vox_st)};
    addr_sweep = sweep_cnt[ChW-1:0];
    if (state == S_SWEEP) begin
      vm_we = 1'b1; m_addr = addr_sweep;
    end else if (state == S_WR) begin
      vm_we = 1'b1; vm_wd = 1'b1; dm_we = 1'b1;
    end
  end
endmodule

// File: rtl/veta_checker.sv
// Port-level checker for the accumulator, bound to the top level.
`timescale 1ns / 1ps
module veta_props (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input veta_pkg::out_item_t out_data
);
  import veta_pkg::*;
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("out held");
  a_in_once: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready) else $error("ready right after transaction");
  a_zero_reject: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.accepted |-> out_data.energy_total == '0) else $error("zero result");
  a_new_energy: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.accepted |-> out_data.energy_total != '0) else $error("energy zero");
endmodule

bind voxel_energy_time_accumulator veta_props u_chk (
  .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data));
